>>> rtl/tlc_pkg.sv
// package for the two-level cache tag model: geometry, types, plru helpers
// no dependencies
package tlc_pkg;
    localparam int LINE_BYTES  = 64;
    localparam int L1_SETS     = 64;
    localparam int L1_WAYS     = 4;
    localparam int L2_SETS     = 512;
    localparam int L2_WAYS     = 8;
    localparam int OFF_W       = $clog2(LINE_BYTES);
    localparam int L1_IDX_W    = $clog2(L1_SETS);
    localparam int L2_IDX_W    = $clog2(L2_SETS);
    localparam int L1_WAY_W    = $clog2(L1_WAYS);
    localparam int L2_WAY_W    = $clog2(L2_WAYS);
    localparam int L1_TAG_W    = 32 - OFF_W - L1_IDX_W;
    localparam int L2_TAG_W    = 32 - OFF_W - L2_IDX_W;
    localparam int L1_TREE_W   = L1_WAYS - 1;
    localparam int L2_TREE_W   = L2_WAYS - 1;
    // one row per set: valid bits, tree bits, tags
    localparam int L1_ROW_W    = L1_WAYS + L1_TREE_W + L1_WAYS * L1_TAG_W;
    localparam int L2_ROW_W    = L2_WAYS + L2_TREE_W + L2_WAYS * L2_TAG_W;

    localparam logic [1:0] CFG_L2_EN  = 2'd0;
    localparam logic [1:0] CFG_L1_LAT = 2'd1;
    localparam logic [1:0] CFG_L2_LAT = 2'd2;
    localparam logic [1:0] CFG_MEM_LAT = 2'd3;

    localparam logic [1:0] LVL_UNCACHED = 2'd0;
    localparam logic [1:0] LVL_L1       = 2'd1;
    localparam logic [1:0] LVL_L2       = 2'd2;
    localparam logic [1:0] LVL_MEM      = 2'd3;

    typedef enum logic [1:0] {
        t_ST_IDLE, t_ST_LOOK, t_ST_OUT, t_ST_CLR
    } t_state;

    typedef struct packed {
        logic [1:0] level;
        logic       l1_we;
        logic       l2_we;
    } t_decision;

    // walk pointing every node on the path away from way
    function automatic logic [15:0] plru_mark(input logic [15:0] tree,
                                              input logic [3:0] way,
                                              input int depth);
        logic [15:0] t;
        int node;
        t = tree;
        node = 0;
        for (int l = 0; l < 4; l++) begin
            if (l < depth) begin
                if (way[depth - 1 - l]) begin
                    t[node] = 1'b0;
                    node = 2 * node + 2;
                end else begin
                    t[node] = 1'b1;
                    node = 2 * node + 1;
                end
            end
        end
        return t;
    endfunction

    // victim way of the tree
    function automatic logic [3:0] plru_victim(input logic [15:0] tree,
                                               input int depth);
        logic [3:0] w;
        int node;
        w = 4'd0;
        node = 0;
        for (int l = 0; l < 4; l++) begin
            if (l < depth) begin
                w = {w[2:0], tree[node]};
                node = tree[node] ? 2 * node + 2 : 2 * node + 1;
            end
        end
        return w;
    endfunction
endpackage

>>> rtl/tlc_ram.sv
// generic single-port-write ram with registered read
// no dependencies
module tlc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> rtl/tlc_level.sv
// one cache level: tag/valid/plru row lookup and row update
// depends on tlc_pkg
module tlc_level_l1 (
    input  logic                         i_row_ok,
    input  logic [tlc_pkg::L1_ROW_W-1:0] i_row,
    input  logic [tlc_pkg::L1_TAG_W-1:0] i_tag,
    output logic                         o_hit,
    output logic [tlc_pkg::L1_ROW_W-1:0] o_row_hit,
    output logic [tlc_pkg::L1_ROW_W-1:0] o_row_fill
);
    localparam int W = tlc_pkg::L1_WAYS;
    localparam int TW = tlc_pkg::L1_TAG_W;
    localparam int RW = tlc_pkg::L1_TREE_W;
    logic [W-1:0]  v;
    logic [RW-1:0] tr;
    logic [tlc_pkg::L1_WAY_W-1:0] hw, vw;
    logic [15:0] tm, tv;
    logic [W*TW-1:0] tags, ntags;
    logic [W-1:0] nv;
    always_comb begin
        v    = i_row_ok ? i_row[W+RW+W*TW-1 -: W] : '0;
        tr   = i_row_ok ? i_row[W*TW+RW-1 -: RW] : '0;
        tags = i_row[W*TW-1:0];
        o_hit = 1'b0;
        hw = '0;
        for (int w = W - 1; w >= 0; w--) begin
            if (v[w] && tags[w*TW +: TW] == i_tag) begin
                o_hit = 1'b1;
                hw = tlc_pkg::L1_WAY_W'(w);
            end
        end
        tm = tlc_pkg::plru_mark(16'(tr), 4'(hw), tlc_pkg::L1_WAY_W);
        o_row_hit = {v, tm[RW-1:0], tags};
        vw = tlc_pkg::L1_WAY_W'(tlc_pkg::plru_victim(16'(tr), tlc_pkg::L1_WAY_W));
        tv = tlc_pkg::plru_mark(16'(tr), 4'(vw), tlc_pkg::L1_WAY_W);
        ntags = tags;
        ntags[vw*TW +: TW] = i_tag;
        nv = v;
        nv[vw] = 1'b1;
        o_row_fill = {nv, tv[RW-1:0], ntags};
    end
endmodule

>>> rtl/tlc_level2.sv
// second cache level: tag/valid/plru row lookup and row update
// depends on tlc_pkg
module tlc_level2 (
    input  logic                         i_row_ok,
    input  logic [tlc_pkg::L2_ROW_W-1:0] i_row,
    input  logic [tlc_pkg::L2_TAG_W-1:0] i_tag,
    output logic                         o_hit,
    output logic [tlc_pkg::L2_ROW_W-1:0] o_row_hit,
    output logic [tlc_pkg::L2_ROW_W-1:0] o_row_fill
);
    localparam int W = tlc_pkg::L2_WAYS;
    localparam int TW = tlc_pkg::L2_TAG_W;
    localparam int RW = tlc_pkg::L2_TREE_W;
    logic [W-1:0]  v;
    logic [RW-1:0] tr;
    logic [tlc_pkg::L2_WAY_W-1:0] hw, vw;
    logic [15:0] tm, tv;
    logic [W*TW-1:0] tags, ntags;
    logic [W-1:0] nv;
    always_comb begin
        v    = i_row_ok ? i_row[W+RW+W*TW-1 -: W] : '0;
        tr   = i_row_ok ? i_row[W*TW+RW-1 -: RW] : '0;
        tags = i_row[W*TW-1:0];
        o_hit = 1'b0;
        hw = '0;
        for (int w = W - 1; w >= 0; w--) begin
            if (v[w] && tags[w*TW +: TW] == i_tag) begin
                o_hit = 1'b1;
                hw = tlc_pkg::L2_WAY_W'(w);
            end
        end
        tm = tlc_pkg::plru_mark(16'(tr), 4'(hw), tlc_pkg::L2_WAY_W);
        o_row_hit = {v, tm[RW-1:0], tags};
        vw = tlc_pkg::L2_WAY_W'(tlc_pkg::plru_victim(16'(tr), tlc_pkg::L2_WAY_W));
        tv = tlc_pkg::plru_mark(16'(tr), 4'(vw), tlc_pkg::L2_WAY_W);
        ntags = tags;
        ntags[vw*TW +: TW] = i_tag;
        nv = v;
        nv[vw] = 1'b1;
        o_row_fill = {nv, tv[RW-1:0], ntags};
    end
endmodule

>>> rtl/two_level_cache_tag_plru_model_unit.sv
// two-level cache tag model with tree plru, top level
// depends on tlc_pkg, tlc_ram, tlc_level_l1, tlc_level2
// an accepted access passes the lookup state (row read, lookup), then the output state;
// a new access is taken only in the idle state, once the last result has been taken
// reset: state and config registers load defaults; a written flag per l1 row masks rows never written,
// the 512 l2 rows get a clearing pass after reset, during which no input is taken
module two_level_cache_tag_plru_model_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // access_address[31:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // access_latency[7:0], hit_level[9:8], zero[15:10]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);
    tlc_pkg::t_state r_state, n_state;
    logic       r_l2_en;
    logic [7:0] r_l1_lat, r_l2_lat, r_mem_lat;
    logic [31:0] r_addr;
    logic [7:0]  r_lat;
    logic [1:0]  r_lvl;
    logic [tlc_pkg::L1_SETS-1:0] r_l1_ok;   // row written since reset
    logic [tlc_pkg::L2_IDX_W-1:0] r_clr;     // clearing pass counter
    tlc_pkg::t_decision dec;

    logic [tlc_pkg::L1_IDX_W-1:0] set1, rd_set1;
    logic [tlc_pkg::L2_IDX_W-1:0] set2, rd_set2, l2_waddr;
    logic [tlc_pkg::L1_TAG_W-1:0] tag1;
    logic [tlc_pkg::L2_TAG_W-1:0] tag2;
    logic [tlc_pkg::L1_ROW_W-1:0] l1_rd, l1_hit_row, l1_fill_row;
    logic [tlc_pkg::L2_ROW_W-1:0] l2_rd, l2_hit_row, l2_fill_row, l2_wd;
    logic l1_hit, l2_hit, l1_we, l2_we;

    assign o_cfg_ready = 1'b1;
    // the rams read the set of the incoming address at the accepting edge,
    // so the rows are ready in the lookup cycle
    assign rd_set1 = s_axis_tdata[tlc_pkg::OFF_W +: tlc_pkg::L1_IDX_W];
    assign rd_set2 = s_axis_tdata[tlc_pkg::OFF_W +: tlc_pkg::L2_IDX_W];
    // the address register stays stable during lookup and write-back
    assign set1 = r_addr[tlc_pkg::OFF_W +: tlc_pkg::L1_IDX_W];
    assign set2 = r_addr[tlc_pkg::OFF_W +: tlc_pkg::L2_IDX_W];
    assign tag1 = r_addr[31 -: tlc_pkg::L1_TAG_W];
    assign tag2 = r_addr[31 -: tlc_pkg::L2_TAG_W];

    tlc_ram #(.WIDTH(tlc_pkg::L1_ROW_W), .DEPTH(tlc_pkg::L1_SETS)) u_l1 (
        .i_clk(i_clk), .i_we(l1_we), .i_waddr(set1),
        .i_wdata(l2_hit || !dec.l2_we ? (l1_hit ? l1_hit_row : l1_fill_row) : l1_fill_row),
        .i_raddr(rd_set1), .o_rdata(l1_rd));
    tlc_ram #(.WIDTH(tlc_pkg::L2_ROW_W), .DEPTH(tlc_pkg::L2_SETS)) u_l2 (
        .i_clk(i_clk), .i_we(l2_we), .i_waddr(l2_waddr), .i_wdata(l2_wd),
        .i_raddr(rd_set2), .o_rdata(l2_rd));

    tlc_level_l1 u_lk1 (.i_row_ok(r_l1_ok[set1]), .i_row(l1_rd), .i_tag(tag1),
        .o_hit(l1_hit), .o_row_hit(l1_hit_row), .o_row_fill(l1_fill_row));
    // l2 rows are all cleared before use, so every row read is valid
    tlc_level2 u_lk2 (.i_row_ok(1'b1), .i_row(l2_rd), .i_tag(tag2),
        .o_hit(l2_hit), .o_row_hit(l2_hit_row), .o_row_fill(l2_fill_row));

    // what the lookup decides for this access
    always_comb begin
        dec = '0;
        if (!r_addr[31]) begin
            dec.level = tlc_pkg::LVL_UNCACHED;
        end else if (l1_hit) begin
            dec.level = tlc_pkg::LVL_L1;
            dec.l1_we = 1'b1;
        end else if (!r_l2_en) begin
            dec.level = tlc_pkg::LVL_MEM;
            dec.l1_we = 1'b1;
        end else if (l2_hit) begin
            dec.level = tlc_pkg::LVL_L2;
            dec.l1_we = 1'b1;
            dec.l2_we = 1'b1;
        end else begin
            dec.level = tlc_pkg::LVL_MEM;
            dec.l1_we = 1'b1;
            dec.l2_we = 1'b1;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tlc_pkg::t_ST_CLR: begin
                if (r_clr == tlc_pkg::L2_IDX_W'(tlc_pkg::L2_SETS - 1)) begin
                    n_state = tlc_pkg::t_ST_IDLE;
                end
            end
            tlc_pkg::t_ST_IDLE: if (s_axis_tvalid) n_state = tlc_pkg::t_ST_LOOK;
            tlc_pkg::t_ST_LOOK: n_state = tlc_pkg::t_ST_OUT;
            tlc_pkg::t_ST_OUT:  if (m_axis_tready) n_state = tlc_pkg::t_ST_IDLE;
            default:            n_state = tlc_pkg::t_ST_IDLE;
        endcase
    end

    // outputs and ram write controls
    always_comb begin
        s_axis_tready = (r_state == tlc_pkg::t_ST_IDLE);
        m_axis_tvalid = (r_state == tlc_pkg::t_ST_OUT);
        m_axis_tdata  = {6'd0, r_lvl, r_lat};
        l1_we    = (r_state == tlc_pkg::t_ST_LOOK) && dec.l1_we;
        l2_we    = (r_state == tlc_pkg::t_ST_CLR) ||
                   ((r_state == tlc_pkg::t_ST_LOOK) && dec.l2_we);
        l2_waddr = (r_state == tlc_pkg::t_ST_CLR) ? r_clr : set2;
        l2_wd    = (r_state == tlc_pkg::t_ST_CLR) ? '0 :
                   (l2_hit ? l2_hit_row : l2_fill_row);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= tlc_pkg::t_ST_CLR;
            r_clr     <= '0;
            r_l1_ok   <= '0;
            r_l2_en   <= 1'b1;
            r_l1_lat  <= 8'd1;
            r_l2_lat  <= 8'd10;
            r_mem_lat <= 8'd50;
        end else begin
            r_state <= n_state;
            if (r_state == tlc_pkg::t_ST_CLR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (l1_we) begin
                r_l1_ok[set1] <= 1'b1;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    tlc_pkg::CFG_L2_EN:   r_l2_en   <= i_cfg_data[0];
                    tlc_pkg::CFG_L1_LAT:  r_l1_lat  <= i_cfg_data;
                    tlc_pkg::CFG_L2_LAT:  r_l2_lat  <= i_cfg_data;
                    tlc_pkg::CFG_MEM_LAT: r_mem_lat <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_addr <= s_axis_tdata;
        end
        if (r_state == tlc_pkg::t_ST_LOOK) begin
            r_lvl <= dec.level;
            case (dec.level)
                tlc_pkg::LVL_L2:  r_lat <= r_l2_lat;
                tlc_pkg::LVL_MEM: r_lat <= r_mem_lat;
                default:          r_lat <= r_l1_lat;
            endcase
        end
    end
endmodule

>>> tb/sv/tb_two_level_cache_tag_plru_model_unit.sv
// testbench for two_level_cache_tag_plru_model_unit: drives access addresses and
// checks each latency/level result against an in-bench two-level tag and plru predictor
// depends on tlc_pkg and the rtl of the block
`timescale 1ns / 100ps

module tb_two_level_cache_tag_plru_model_unit;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // access_address[31:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;        // access_latency[7:0], hit_level[9:8], zero[15:10]
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [7:0]  i_cfg_data = '0;

    two_level_cache_tag_plru_model_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // predictor copy of the registers
    logic       l2_enable = 1'b1;
    logic [7:0] l1_latency = 8'd1;
    logic [7:0] l2_latency = 8'd10;
    logic [7:0] mem_latency = 8'd50;

    // predictor copy of the tag stores
    logic [tlc_pkg::L1_TAG_W-1:0]  l1_tag   [tlc_pkg::L1_SETS][tlc_pkg::L1_WAYS];
    logic                          l1_vld   [tlc_pkg::L1_SETS][tlc_pkg::L1_WAYS];
    logic [tlc_pkg::L1_TREE_W-1:0] l1_tree  [tlc_pkg::L1_SETS];
    logic [tlc_pkg::L2_TAG_W-1:0]  l2_tag   [tlc_pkg::L2_SETS][tlc_pkg::L2_WAYS];
    logic                          l2_vld   [tlc_pkg::L2_SETS][tlc_pkg::L2_WAYS];
    logic [tlc_pkg::L2_TREE_W-1:0] l2_tree  [tlc_pkg::L2_SETS];

    // one expected result
    typedef struct packed {
        logic [7:0] latency;
        logic [1:0] level;
    } t_access_result;

    // expected results in order, written at input transfer, read at output transfer
    localparam int EXP_DEPTH = 1024;
    t_access_result exp_mem [EXP_DEPTH];
    int  exp_wr = 0;
    int  exp_rd = 0;
    int  mismatch_cnt = 0;
    bit  idle_on = 1'b1;
    bit  hold_req = 1'b0;

    initial begin
        for (int s = 0; s < tlc_pkg::L1_SETS; s++) begin
            l1_tree[s] = '0;
            for (int w = 0; w < tlc_pkg::L1_WAYS; w++) begin
                l1_vld[s][w] = 1'b0;
                l1_tag[s][w] = '0;
            end
        end
        for (int s = 0; s < tlc_pkg::L2_SETS; s++) begin
            l2_tree[s] = '0;
            for (int w = 0; w < tlc_pkg::L2_WAYS; w++) begin
                l2_vld[s][w] = 1'b0;
                l2_tag[s][w] = '0;
            end
        end
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatch_cnt++;
    endtask

    task automatic exp_store(input t_access_result r);
        exp_mem[exp_wr % EXP_DEPTH] = r;
        exp_wr++;
    endtask

    // point every node on the path away from the used way
    function automatic logic [6:0] plru_touch(input logic [6:0] tree, input int depth,
                                              input int way);
        int node;
        node = 0;
        for (int l = 0; l < depth; l++) begin
            if ((way >> (depth - 1 - l)) & 1) begin
                tree[node] = 1'b0;
                node = 2 * node + 2;
            end else begin
                tree[node] = 1'b1;
                node = 2 * node + 1;
            end
        end
        return tree;
    endfunction

    // follow the tree to the victim, flipping each node on the way down
    function automatic int plru_pick_flip(inout logic [6:0] tree, input int depth);
        int node;
        int way;
        logic b;
        node = 0;
        way = 0;
        for (int l = 0; l < depth; l++) begin
            b = tree[node];
            tree[node] = ~b;
            node = b ? 2 * node + 2 : 2 * node + 1;
            way = (way << 1) | int'(b);
        end
        return way;
    endfunction

    function automatic void fill_l1(input logic [31:0] addr);
        int s;
        int w;
        logic [6:0] t;
        s = int'(addr[tlc_pkg::OFF_W +: tlc_pkg::L1_IDX_W]);
        t = 7'(l1_tree[s]);
        w = plru_pick_flip(t, tlc_pkg::L1_WAY_W);
        l1_tree[s] = t[tlc_pkg::L1_TREE_W-1:0];
        l1_tag[s][w] = addr[31 -: tlc_pkg::L1_TAG_W];
        l1_vld[s][w] = 1'b1;
    endfunction

    // full lookup of one access, updating the predictor state
    function automatic t_access_result cache_lookup(input logic [31:0] addr);
        t_access_result r;
        int s1;
        int s2;
        int w;
        logic [6:0] t;
        s1 = int'(addr[tlc_pkg::OFF_W +: tlc_pkg::L1_IDX_W]);
        s2 = int'(addr[tlc_pkg::OFF_W +: tlc_pkg::L2_IDX_W]);
        if (!addr[31]) begin
            r.latency = l1_latency;
            r.level = tlc_pkg::LVL_UNCACHED;
            return r;
        end
        for (int i = 0; i < tlc_pkg::L1_WAYS; i++) begin
            if (l1_vld[s1][i] && l1_tag[s1][i] == addr[31 -: tlc_pkg::L1_TAG_W]) begin
                l1_tree[s1] = tlc_pkg::L1_TREE_W'(plru_touch(7'(l1_tree[s1]),
                                                             tlc_pkg::L1_WAY_W, i));
                r.latency = l1_latency;
                r.level = tlc_pkg::LVL_L1;
                return r;
            end
        end
        if (l2_enable) begin
            for (int i = 0; i < tlc_pkg::L2_WAYS; i++) begin
                if (l2_vld[s2][i] && l2_tag[s2][i] == addr[31 -: tlc_pkg::L2_TAG_W]) begin
                    l2_tree[s2] = plru_touch(l2_tree[s2], tlc_pkg::L2_WAY_W, i);
                    fill_l1(addr);
                    r.latency = l2_latency;
                    r.level = tlc_pkg::LVL_L2;
                    return r;
                end
            end
            // miss in both: second level fill first
            t = l2_tree[s2];
            w = plru_pick_flip(t, tlc_pkg::L2_WAY_W);
            l2_tree[s2] = t;
            l2_tag[s2][w] = addr[31 -: tlc_pkg::L2_TAG_W];
            l2_vld[s2][w] = 1'b1;
        end
        fill_l1(addr);
        r.latency = mem_latency;
        r.level = tlc_pkg::LVL_MEM;
        return r;
    endfunction

    // input transfer; prediction is made at the accepting edge
    task automatic send_access(input logic [31:0] addr);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= addr;
        do @(posedge i_clk); while (!s_axis_tready);
        exp_store(cache_lookup(addr));
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
    endtask

    // register write, only while the block is idle
    task automatic cfg_write(input logic [1:0] idx, input logic [7:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            tlc_pkg::CFG_L2_EN:   l2_enable   = val[0];
            tlc_pkg::CFG_L1_LAT:  l1_latency  = val;
            tlc_pkg::CFG_L2_LAT:  l2_latency  = val;
            tlc_pkg::CFG_MEM_LAT: mem_latency = val;
            default: ;
        endcase
    endtask

    // let every outstanding result drain, then let the pipeline settle
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (exp_wr != exp_rd) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // random address: mostly a small pool of lines that collide in a few sets,
    // so hits, second-level hits and evictions all happen; some full-range noise
    function automatic logic [31:0] rand_address();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return {1'b0, 31'($urandom)};
            default: return 32'h8000_0000 | ($urandom_range(0, 7) << 20)
                            | ($urandom_range(0, 3) << 12) | ($urandom_range(0, 1) << 6)
                            | $urandom_range(0, 63);
        endcase
    endfunction

    // result side: random stall bursts, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_req = 1'b0;
                m_axis_tready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // result checker: every output transfer against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (exp_wr == exp_rd) begin
                report_mismatch($sformatf("unexpected result %h", m_axis_tdata));
            end else begin
                t_access_result e;
                e = exp_mem[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (m_axis_tdata[7:0] !== e.latency)
                    report_mismatch($sformatf("latency %0d, expected %0d",
                                              m_axis_tdata[7:0], e.latency));
                if (m_axis_tdata[9:8] !== e.level)
                    report_mismatch($sformatf("level %0d, expected %0d",
                                              m_axis_tdata[9:8], e.level));
                if (m_axis_tdata[15:10] !== '0)
                    report_mismatch("padding bits not zero");
            end
        end
    end

    // directed rows: address, whether the expected result is typed in, and that result
    typedef struct {
        logic [31:0] addr;
        bit          fixed;
        logic [7:0]  latency;
        logic [1:0]  level;
    } t_directed_row;

    t_directed_row directed_rows[] = '{
        '{32'h0000_0000, 1, 8'd1,  tlc_pkg::LVL_UNCACHED},   // lowest address
        '{32'h7FFF_FFFF, 1, 8'd1,  tlc_pkg::LVL_UNCACHED},   // just below the cached range
        '{32'h8000_0000, 1, 8'd50, tlc_pkg::LVL_MEM},        // first cached line, cold miss
        '{32'h8000_003F, 1, 8'd1,  tlc_pkg::LVL_L1},         // same line, last byte
        '{32'hFFFF_FFFF, 1, 8'd50, tlc_pkg::LVL_MEM},        // highest address
        '{32'hFFFF_FFC0, 1, 8'd1,  tlc_pkg::LVL_L1},
        '{32'h5555_5555, 1, 8'd1,  tlc_pkg::LVL_UNCACHED},
        '{32'hAAAA_AAAA, 1, 8'd50, tlc_pkg::LVL_MEM},
        // five lines into first-level set 0 after 8000_0000: the last two evict via plru
        '{32'h8000_1000, 0, 8'd0, 2'd0},
        '{32'h8000_2000, 0, 8'd0, 2'd0},
        '{32'h8000_3000, 0, 8'd0, 2'd0},
        '{32'h8000_4000, 0, 8'd0, 2'd0},
        '{32'h8000_5000, 0, 8'd0, 2'd0},
        '{32'h8000_0000, 0, 8'd0, 2'd0},            // evicted line back from second level
        '{32'h8000_1000, 0, 8'd0, 2'd0},
        '{32'h8000_8000, 0, 8'd0, 2'd0},            // same second-level set, new tag
        '{32'h8000_8000, 0, 8'd0, 2'd0}
    };

    initial begin
        t_access_result p;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part at reset settings; fixed rows are checked against typed values
        foreach (directed_rows[i]) begin
            p = cache_lookup(directed_rows[i].addr);
            if (directed_rows[i].fixed &&
                (p.latency !== directed_rows[i].latency || p.level !== directed_rows[i].level))
                report_mismatch($sformatf("directed row %0d prediction off", i));
            // the lookup above already advanced the predictor, so queue it directly
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= directed_rows[i].addr;
            do @(posedge i_clk); while (!s_axis_tready);
            exp_store(p);
        end
        drain_results();

        // phase with second level off and extreme latencies; receiver holds off once
        cfg_write(tlc_pkg::CFG_L2_EN, 8'd0);
        cfg_write(tlc_pkg::CFG_L1_LAT, 8'd0);
        cfg_write(tlc_pkg::CFG_L2_LAT, 8'd255);
        cfg_write(tlc_pkg::CFG_MEM_LAT, 8'd255);
        hold_req = 1'b1;
        repeat (130) send_access(rand_address());
        drain_results();

        // second level back on, opposite extremes
        cfg_write(tlc_pkg::CFG_L2_EN, 8'd1);
        cfg_write(tlc_pkg::CFG_L1_LAT, 8'd255);
        cfg_write(tlc_pkg::CFG_L2_LAT, 8'd0);
        cfg_write(tlc_pkg::CFG_MEM_LAT, 8'd0);
        repeat (130) send_access(rand_address());
        drain_results();

        // random settings, wide values keep only their low bits
        cfg_write(tlc_pkg::CFG_L2_EN, 8'($urandom));
        cfg_write(tlc_pkg::CFG_L1_LAT, 8'($urandom));
        cfg_write(tlc_pkg::CFG_L2_LAT, 8'($urandom));
        cfg_write(tlc_pkg::CFG_MEM_LAT, 8'($urandom));
        repeat (130) send_access(rand_address());
        drain_results();

        // last stretch: enabled, no idling on either side
        cfg_write(tlc_pkg::CFG_L2_EN, 8'd1);
        cfg_write(tlc_pkg::CFG_MEM_LAT, 8'd77);
        idle_on = 1'b0;
        repeat (150) send_access(rand_address());
        drain_results();

        if (mismatch_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // run limit
    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end
endmodule
